@@ rtl/kmrd_pkg.sv @@
package kmrd_pkg;

  localparam int unsigned HistBits    = 8;
  localparam int unsigned ColBitsW    = 14;
  localparam int unsigned NowW        = 16;
  localparam int unsigned RowIndexW   = 3;
  localparam int unsigned LenW        = 4;
  localparam logic [3:0]  LenReset    = 4'd5;

  typedef struct packed {
    logic [RowIndexW-1:0] row_index;
    logic [ColBitsW-1:0]  key_bits;
    logic [ColBitsW-1:0]  bounce_bits;
    logic                 scanned;
  } out_beat_t;

endpackage

@@ rtl/key_matrix_row_debouncer.sv @@
// an accepted input beat's result is registered into the output buffer, in the skid entry while a result waits
// throughput: one row beat per cycle while the skid entry is empty (in_stall_o low),
// set by the update of the row history registers and the two-entry output buffer
// reset: asynchronous, active low; clears all key histories, key states, row
// counter, pass timestamp and elapsed time, and sets debounce_len to 5
module key_matrix_row_debouncer
  import kmrd_pkg::*;
#(
  parameter int unsigned ROWS = 5,
  parameter int unsigned COLS = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [LenW-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ColBitsW-1:0]  col_bits_i,
  input  logic [NowW-1:0]      now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [RowIndexW-1:0] row_index_o,
  output logic [ColBitsW-1:0]  key_bits_o,
  output logic [ColBitsW-1:0]  bounce_bits_o,
  output logic                 scanned_o
);

  localparam int unsigned RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);

  logic [LenW-1:0]     len_q;
  logic [RowW-1:0]     row_q, row_d;
  logic [NowW-1:0]     ts_q, ts_d;
  logic [NowW-1:0]     elapsed_q, elapsed_d;
  logic [HistBits-1:0] hist_q [ROWS][COLS];
  logic [HistBits-1:0] hist_row_d [COLS];
  logic [COLS-1:0]     state_q [ROWS];
  logic [COLS-1:0]     state_row_d;
  logic [COLS-1:0]     bounce;
  logic                active;

  out_beat_t out_q, skid_q, beat;
  logic      out_valid_q, skid_valid_q;
  logic      in_fire, out_fire;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  always_comb begin
    logic [3:0]          n;
    logic [3:0]          len;
    logic [HistBits-1:0] mask;
    logic [HistBits-1:0] pat;
    logic [HistBits-1:0] inv;
    logic [2*HistBits-1:0] sh;
    logic                pressed;
    logic [31:0]         row_ext;
    logic [31:0]         key_ext;
    logic [31:0]         bnc_ext;

    elapsed_d = (row_q == '0) ? NowW'(now_ms_i - ts_q) : elapsed_q;
    active    = (elapsed_d != '0);
    ts_d      = (active && row_q == '0) ? now_ms_i : ts_q;
    row_d     = (row_q == LastRow) ? '0 : RowW'(row_q + 1'b1);

    n = (elapsed_d > NowW'(HistBits)) ? 4'd8 : elapsed_d[3:0];
    if (len_q == '0) begin
      len = 4'd1;
    end else if (len_q > 4'd8) begin
      len = 4'd8;
    end else begin
      len = len_q;
    end
    mask = 8'hFF >> (4'd8 - len);

    state_row_d = state_q[row_q];
    bounce      = '0;
    for (int unsigned c = 0; c < COLS; c++) begin
      pressed = (c < ColBitsW) ? col_bits_i[c] : 1'b0;
      sh = {hist_q[row_q][c], {HistBits{pressed}}} << n;
      hist_row_d[c] = active ? sh[2*HistBits-1:HistBits] : hist_q[row_q][c];
      pat = hist_row_d[c] & mask;
      inv = ~(pat | ~mask);
      if (active) begin
        if (pat == '0) begin
          state_row_d[c] = 1'b0;
        end else if ((pat & HistBits'(pat + 1'b1)) == '0) begin
          state_row_d[c] = 1'b1;
        end else if ((inv & HistBits'(inv + 1'b1)) != '0) begin
          // not ones over zeros either
          bounce[c] = 1'b1;
        end
      end
    end

    row_ext = 32'(row_q);
    key_ext = 32'(state_row_d);
    bnc_ext = 32'(bounce);
    beat.row_index   = row_ext[RowIndexW-1:0];
    beat.key_bits    = key_ext[ColBitsW-1:0];
    beat.bounce_bits = bnc_ext[ColBitsW-1:0];
    beat.scanned     = active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LenReset;
      row_q     <= '0;
      ts_q      <= '0;
      elapsed_q <= '0;
      for (int unsigned r = 0; r < ROWS; r++) begin
        state_q[r] <= '0;
        for (int unsigned c = 0; c < COLS; c++) begin
          hist_q[r][c] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        row_q          <= row_d;
        ts_q           <= ts_d;
        elapsed_q      <= elapsed_d;
        state_q[row_q] <= state_row_d;
        for (int unsigned c = 0; c < COLS; c++) begin
          hist_q[row_q][c] <= hist_row_d[c];
        end
      end
    end
  end

  // two-entry output buffer so an input beat is taken while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= beat;
      end else begin
        skid_q <= beat;
      end
    end else if (out_fire && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_index_o   = out_q.row_index;
  assign key_bits_o    = out_q.key_bits;
  assign bounce_bits_o = out_q.bounce_bits;
  assign scanned_o     = out_q.scanned;

endmodule
